// File: rtl/pcvd_pkg.sv
package pcvd_pkg;

	// Field widths
	localparam int unsigned COORD_W = 16;
	localparam int unsigned COLOR_W = 24;
	localparam int unsigned PIX_W   = 12;
	localparam int unsigned CNT_W   = 20;
	localparam int unsigned LIM_W   = 32;

	// Configuration port
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_POINT_LIMIT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ELLIPSE_LIMIT = 1'd1;
	localparam logic [CNT_W-1:0] POINT_LIMIT_RST   = 20'd92160;
	localparam logic [LIM_W-1:0] ELLIPSE_LIMIT_RST = 32'd50000000;

	// Default geometry
	localparam int unsigned SKIP_DEF        = 2;
	localparam int unsigned X_CELL_BITS_DEF = 6;
	localparam int unsigned Y_CELL_BITS_DEF = 5;
	localparam int unsigned Z_CELL_BITS_DEF = 6;

	// Crop box in mm
	localparam logic signed [COORD_W-1:0] BOX_X_MIN = 16'sd0;
	localparam logic signed [COORD_W-1:0] BOX_X_MAX = 16'sd5000;
	localparam logic signed [COORD_W-1:0] BOX_Y_MIN = -16'sd3000;
	localparam logic signed [COORD_W-1:0] BOX_Y_MAX = 16'sd3000;
	localparam logic signed [COORD_W-1:0] BOX_Z_MIN = -16'sd100;
	localparam logic signed [COORD_W-1:0] BOX_Z_MAX = 16'sd2000;

	// In-box magnitudes fit 13 bits; |c|/50 fits 7 bits
	localparam int unsigned MAG_W = 13;
	localparam int unsigned Q_W   = 7;
	localparam int unsigned CQ_W  = 8;
	// floor(a/50) == (a*5243) >> 18, exact for a <= 5000
	localparam logic [MAG_W-1:0] VOXEL_MUL   = 13'd5243;
	localparam int unsigned      VOXEL_SHIFT = 18;

	// Row/column reciprocal for the skip test
	localparam int unsigned SKIP_SHIFT = 16;
	localparam int unsigned SKIP_MUL_W = 17;
	localparam int unsigned SKIP_W     = 4;

	// Occupancy word: 32 cell bits plus a frame epoch tag
	localparam int unsigned EPOCH_BITS = 8;
	localparam int unsigned OCC_BITS   = 32;
	localparam int unsigned BIT_IDX_W  = 5;

	typedef struct packed {
		logic [EPOCH_BITS-1:0] tag;
		logic [OCC_BITS-1:0]   bits;
	} occ_word_t;

	localparam int unsigned OCC_WORD_W = $bits(occ_word_t);

endpackage

// File: rtl/pcvd_in_if.sv
interface pcvd_in_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [pcvd_pkg::COORD_W-1:0]      x_mm;
	logic signed [pcvd_pkg::COORD_W-1:0]      y_mm;
	logic signed [pcvd_pkg::COORD_W-1:0]      z_mm;
	logic        [pcvd_pkg::COLOR_W-1:0]      color_word;
	logic                                     is_finite;
	logic        [pcvd_pkg::PIX_W-1:0]        pixel_row;
	logic        [pcvd_pkg::PIX_W-1:0]        pixel_col;
	logic                                     frame_start;
	logic                                     frame_end;

	modport source (
		output valid, x_mm, y_mm, z_mm, color_word, is_finite,
		       pixel_row, pixel_col, frame_start, frame_end,
		input  ready
	);
	modport sink (
		input  valid, x_mm, y_mm, z_mm, color_word, is_finite,
		       pixel_row, pixel_col, frame_start, frame_end,
		output ready
	);
endinterface

// File: rtl/pcvd_out_if.sv
interface pcvd_out_if;
	logic                                     valid;
	logic                                     ready;
	logic                                     point_kept;
	logic signed [pcvd_pkg::COORD_W-1:0]      out_x_mm;
	logic signed [pcvd_pkg::COORD_W-1:0]      out_y_mm;
	logic signed [pcvd_pkg::COORD_W-1:0]      out_z_mm;
	logic        [pcvd_pkg::COLOR_W-1:0]      out_color;
	logic        [pcvd_pkg::CNT_W-1:0]        kept_count;
	logic                                     frame_done;

	modport source (
		output valid, point_kept, out_x_mm, out_y_mm, out_z_mm, out_color,
		       kept_count, frame_done,
		input  ready
	);
	modport sink (
		input  valid, point_kept, out_x_mm, out_y_mm, out_z_mm, out_color,
		       kept_count, frame_done,
		output ready
	);
endinterface

// File: rtl/pcvd_ram.sv
module pcvd_ram #(
	parameter int unsigned WIDTH = pcvd_pkg::OCC_WORD_W,
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port; a read of the address being
	// written returns the old contents
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/point_crop_voxel_dedup_core.sv
// Box crop, ellipse gate and first-point-per-voxel filter for an organized
// depth-camera cloud.
// in:  one pixel per beat (coordinates in mm, color, finite flag, row/col,
//      frame_start / frame_end markers), valid/ready.
// out: one beat per emitted point, plus one beat for each frame_end pixel
//      carrying the frame's kept count (point_kept=0 if that pixel was dropped).
// cfg: cfg_we/cfg_index/cfg_data write point_limit (0) and ellipse_limit (1);
//      write only while no beats are in flight.
// Throughput is one pixel per cycle while no clearing pass runs and out
// does not stall: the occupancy RAM is read two stages after accept and
// written back in the next stage, with a one-entry forward of the
// previous write.
// Occupancy words carry an 8-bit frame epoch, so a frame start needs no
// clearing pass. After reset, and at the frame start that finds the epoch
// at its top value (the 256th frame start after reset, then every 255th),
// a clearing pass sweeps all 2^(X+Y+Z cell bits - 5) RAM words (4096 at
// the default geometry) with ready low. The wrap pass waits for the
// pipeline to drain first.
// When out is stalled, pixels that yield no result still flow; a pixel that
// yields a result holds the pipeline until the output register is free.
module point_crop_voxel_dedup_core #(
	parameter int unsigned SKIP        = pcvd_pkg::SKIP_DEF,
	parameter int unsigned X_CELL_BITS = pcvd_pkg::X_CELL_BITS_DEF,
	parameter int unsigned Y_CELL_BITS = pcvd_pkg::Y_CELL_BITS_DEF,
	parameter int unsigned Z_CELL_BITS = pcvd_pkg::Z_CELL_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pcvd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pcvd_pkg::CFG_DATA_W-1:0]    cfg_data,
	pcvd_in_if.sink                            in,
	pcvd_out_if.source                         out
);

	localparam int unsigned CELL_BITS = X_CELL_BITS + Y_CELL_BITS + Z_CELL_BITS;
	localparam int unsigned WADDR_W   = CELL_BITS - pcvd_pkg::BIT_IDX_W;
	localparam int unsigned RAM_DEPTH = 2 ** WADDR_W;
	localparam logic [pcvd_pkg::SKIP_MUL_W-1:0] SKIP_MUL =
		pcvd_pkg::SKIP_MUL_W'((2 ** pcvd_pkg::SKIP_SHIFT + SKIP - 1) / SKIP);
	localparam logic [pcvd_pkg::SKIP_W-1:0] SKIP_V = pcvd_pkg::SKIP_W'(SKIP);

	localparam int unsigned MAG_W = pcvd_pkg::MAG_W;
	localparam int unsigned Q_W   = pcvd_pkg::Q_W;
	localparam int unsigned CQ_W  = pcvd_pkg::CQ_W;
	localparam int unsigned PIX_W = pcvd_pkg::PIX_W;
	localparam int unsigned EP_W  = pcvd_pkg::EPOCH_BITS;
	localparam int unsigned CNT_W = pcvd_pkg::CNT_W;

	typedef enum logic {ST_CLEAR, ST_RUN} state_t;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [CNT_W-1:0]           point_limit_q;
	logic [pcvd_pkg::LIM_W-1:0] ellipse_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_limit_q   <= pcvd_pkg::POINT_LIMIT_RST;
			ellipse_limit_q <= pcvd_pkg::ELLIPSE_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pcvd_pkg::CFG_POINT_LIMIT:   point_limit_q   <= cfg_data[CNT_W-1:0];
				pcvd_pkg::CFG_ELLIPSE_LIMIT: ellipse_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Declarations
	// ---------------------------------------------------------------
	state_t               state_q;
	logic [WADDR_W-1:0]   clr_cnt_q;
	logic [EP_W-1:0]      epoch_q;

	logic                 adv;
	logic                 accept;
	logic                 wrap_req;
	logic                 pipe_empty;

	// stage 1: captured beat
	logic                                valid_s1;
	logic signed [pcvd_pkg::COORD_W-1:0] x_s1, y_s1, z_s1;
	logic [pcvd_pkg::COLOR_W-1:0]        color_s1;
	logic                                finite_s1;
	logic [PIX_W-1:0]                    row_s1, col_s1;
	logic                                fstart_s1, fend_s1;
	logic [EP_W-1:0]                     epoch_s1;

	// stage 2: products
	logic                                valid_s2;
	logic signed [pcvd_pkg::COORD_W-1:0] x_s2, y_s2, z_s2;
	logic [pcvd_pkg::COLOR_W-1:0]        color_s2;
	logic                                inbox_s2;
	logic [PIX_W-1:0]                    row_s2, col_s2, qr_s2, qc_s2;
	logic                                fstart_s2, fend_s2;
	logic [EP_W-1:0]                     epoch_s2;
	logic [2*MAG_W-1:0]                  sqx_s2, sqy_s2;
	logic [Q_W-1:0]                      qx_s2, qy_s2, qz_s2;

	// stage 3: RAM read in flight
	logic                                valid_s3;
	logic signed [pcvd_pkg::COORD_W-1:0] x_s3, y_s3, z_s3;
	logic [pcvd_pkg::COLOR_W-1:0]        color_s3;
	logic                                cand_s3;
	logic                                fstart_s3, fend_s3;
	logic [EP_W-1:0]                     epoch_s3;
	logic [WADDR_W-1:0]                  waddr_s3;
	logic [pcvd_pkg::BIT_IDX_W-1:0]      bit_s3;

	// last RAM write, for forwarding
	logic                                wr_vld_q;
	logic [WADDR_W-1:0]                  wr_addr_q;
	pcvd_pkg::occ_word_t                 wr_data_q;

	// output register
	logic                                out_valid_q;
	logic                                kept_q;
	logic signed [pcvd_pkg::COORD_W-1:0] out_x_q, out_y_q, out_z_q;
	logic [pcvd_pkg::COLOR_W-1:0]        out_color_q;
	logic [CNT_W-1:0]                    cnt_out_q;
	logic                                done_q;

	logic [CNT_W-1:0]                    cnt_q;

	// ---------------------------------------------------------------
	// Handshake and pipeline advance
	// ---------------------------------------------------------------
	logic                 kept;
	logic                 emits;
	logic [CNT_W-1:0]     cnt_new;

	assign emits      = valid_s3 && (kept || fend_s3);
	assign adv        = !emits || !out_valid_q || out.ready;
	assign wrap_req   = in.valid && in.frame_start && (epoch_q == {EP_W{1'b1}});
	assign in.ready   = adv && (state_q == ST_RUN) && !wrap_req;
	assign accept     = in.valid && in.ready;
	assign pipe_empty = !valid_s1 && !valid_s2 && !valid_s3;

	// Clear sequencer and frame epoch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			epoch_q   <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == {WADDR_W{1'b1}}) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (wrap_req && pipe_empty) begin
						state_q   <= ST_CLEAR;
						clr_cnt_q <= '0;
						epoch_q   <= '0;
					end else if (accept && in.frame_start) begin
						epoch_q <= epoch_q + 1'b1;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: capture
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && accept) begin
			x_s1      <= in.x_mm;
			y_s1      <= in.y_mm;
			z_s1      <= in.z_mm;
			color_s1  <= in.color_word;
			finite_s1 <= in.is_finite;
			row_s1    <= in.pixel_row;
			col_s1    <= in.pixel_col;
			fstart_s1 <= in.frame_start;
			fend_s1   <= in.frame_end;
			epoch_s1  <= in.frame_start ? epoch_q + 1'b1 : epoch_q;
		end
	end

	// Box test, magnitudes, squares and reciprocal products
	logic                             inbox_s1;
	logic [pcvd_pkg::COORD_W-1:0]     ay16, az16;
	logic [MAG_W-1:0]                 magx, magy, magz;
	logic [2*MAG_W-1:0]               px, py, pz;
	logic [PIX_W+pcvd_pkg::SKIP_MUL_W-1:0] pr, pc;

	always_comb begin
		inbox_s1 = finite_s1 &&
			x_s1 >= pcvd_pkg::BOX_X_MIN && x_s1 <= pcvd_pkg::BOX_X_MAX &&
			y_s1 >= pcvd_pkg::BOX_Y_MIN && y_s1 <= pcvd_pkg::BOX_Y_MAX &&
			z_s1 >= pcvd_pkg::BOX_Z_MIN && z_s1 <= pcvd_pkg::BOX_Z_MAX;
		ay16 = y_s1[pcvd_pkg::COORD_W-1] ? (16'd0 - y_s1) : y_s1;
		az16 = z_s1[pcvd_pkg::COORD_W-1] ? (16'd0 - z_s1) : z_s1;
		magx = x_s1[MAG_W-1:0];
		magy = ay16[MAG_W-1:0];
		magz = az16[MAG_W-1:0];
		px   = magx * pcvd_pkg::VOXEL_MUL;
		py   = magy * pcvd_pkg::VOXEL_MUL;
		pz   = magz * pcvd_pkg::VOXEL_MUL;
		pr   = row_s1 * SKIP_MUL;
		pc   = col_s1 * SKIP_MUL;
	end

	// ---------------------------------------------------------------
	// Stage 2: ellipse gate, skip test, cell index, RAM read
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			z_s2      <= z_s1;
			color_s2  <= color_s1;
			inbox_s2  <= inbox_s1;
			row_s2    <= row_s1;
			col_s2    <= col_s1;
			qr_s2     <= pr[pcvd_pkg::SKIP_SHIFT +: PIX_W];
			qc_s2     <= pc[pcvd_pkg::SKIP_SHIFT +: PIX_W];
			fstart_s2 <= fstart_s1;
			fend_s2   <= fend_s1;
			epoch_s2  <= epoch_s1;
			sqx_s2    <= magx * magx;
			sqy_s2    <= magy * magy;
			qx_s2     <= px[pcvd_pkg::VOXEL_SHIFT +: Q_W];
			qy_s2     <= py[pcvd_pkg::VOXEL_SHIFT +: Q_W];
			qz_s2     <= pz[pcvd_pkg::VOXEL_SHIFT +: Q_W];
		end
	end

	logic [pcvd_pkg::LIM_W-1:0]          sx32, sy32, ell;
	logic [PIX_W+pcvd_pkg::SKIP_W-1:0]   rb, cb;
	logic                                skip_ok;
	logic                                cand_s2;
	logic [CQ_W-1:0]                     cx8, cy8, cz8;
	logic [CELL_BITS-1:0]                cell_idx;

	always_comb begin
		// 6x^2 + 100y^2 by shifts and adds
		sx32 = pcvd_pkg::LIM_W'(sqx_s2);
		sy32 = pcvd_pkg::LIM_W'(sqy_s2);
		ell  = (sx32 << 2) + (sx32 << 1) + (sy32 << 6) + (sy32 << 5) + (sy32 << 2);
		rb   = qr_s2 * SKIP_V;
		cb   = qc_s2 * SKIP_V;
		skip_ok = (rb == (PIX_W + pcvd_pkg::SKIP_W)'(row_s2)) &&
			(cb == (PIX_W + pcvd_pkg::SKIP_W)'(col_s2));
		cand_s2 = inbox_s2 && skip_ok && (ell <= ellipse_limit_q);
		// trunc toward zero, then wrap per axis
		cx8 = CQ_W'(qx_s2);
		cy8 = y_s2[pcvd_pkg::COORD_W-1] ? (CQ_W'(0) - CQ_W'(qy_s2)) : CQ_W'(qy_s2);
		cz8 = z_s2[pcvd_pkg::COORD_W-1] ? (CQ_W'(0) - CQ_W'(qz_s2)) : CQ_W'(qz_s2);
		cell_idx = {cx8[X_CELL_BITS-1:0], cy8[Y_CELL_BITS-1:0], cz8[Z_CELL_BITS-1:0]};
	end

	// ---------------------------------------------------------------
	// Stage 3: read-modify-write of the occupancy word
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s3      <= x_s2;
			y_s3      <= y_s2;
			z_s3      <= z_s2;
			color_s3  <= color_s2;
			cand_s3   <= cand_s2;
			fstart_s3 <= fstart_s2;
			fend_s3   <= fend_s2;
			epoch_s3  <= epoch_s2;
			waddr_s3  <= cell_idx[CELL_BITS-1:pcvd_pkg::BIT_IDX_W];
			bit_s3    <= cell_idx[pcvd_pkg::BIT_IDX_W-1:0];
		end
	end

	logic [pcvd_pkg::OCC_WORD_W-1:0] rd_raw;
	logic [pcvd_pkg::OCC_WORD_W-1:0] wr_raw;
	pcvd_pkg::occ_word_t             rd_word, cur_word, new_word;
	logic [pcvd_pkg::OCC_BITS-1:0]   cur_bits;
	logic [CNT_W-1:0]                cnt_base;
	logic                            ram_we;
	logic [WADDR_W-1:0]              ram_waddr;

	always_comb begin
		rd_word  = pcvd_pkg::occ_word_t'(rd_raw);
		// previous write landed in the same cycle as this read
		cur_word = (wr_vld_q && wr_addr_q == waddr_s3) ? wr_data_q : rd_word;
		// a word from an older frame reads as empty
		cur_bits = (cur_word.tag == epoch_s3) ? cur_word.bits : '0;
		cnt_base = fstart_s3 ? '0 : cnt_q;
		kept     = valid_s3 && cand_s3 && (cnt_base < point_limit_q) && !cur_bits[bit_s3];
		cnt_new  = cnt_base + CNT_W'(kept);
		new_word.tag  = epoch_s3;
		new_word.bits = cur_bits | (pcvd_pkg::OCC_BITS'(1) << bit_s3);
	end

	// Write port: clearing sweep or pipeline write-back
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			wr_raw    = '0;
		end else begin
			ram_we    = adv && kept;
			ram_waddr = waddr_s3;
			wr_raw    = new_word;
		end
	end

	pcvd_ram #(
		.WIDTH (pcvd_pkg::OCC_WORD_W),
		.DEPTH (RAM_DEPTH),
		.AW    (WADDR_W)
	) u_occ_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_raw),
		.re    (adv),
		.raddr (cell_idx[CELL_BITS-1:pcvd_pkg::BIT_IDX_W]),
		.rdata (rd_raw)
	);

	// Forward register and frame count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
			cnt_q    <= '0;
		end else if (state_q == ST_CLEAR) begin
			wr_vld_q <= 1'b0;
		end else if (adv) begin
			wr_vld_q <= kept;
			if (valid_s3) begin
				cnt_q <= cnt_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && kept) begin
			wr_addr_q <= waddr_s3;
			wr_data_q <= new_word;
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && emits) begin
			out_valid_q <= 1'b1;
		end else if (out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emits) begin
			kept_q      <= kept;
			out_x_q     <= kept ? x_s3 : '0;
			out_y_q     <= kept ? y_s3 : '0;
			out_z_q     <= kept ? z_s3 : '0;
			out_color_q <= kept ? color_s3 : '0;
			cnt_out_q   <= cnt_new;
			done_q      <= fend_s3;
		end
	end

	assign out.valid      = out_valid_q;
	assign out.point_kept = kept_q;
	assign out.out_x_mm   = out_x_q;
	assign out.out_y_mm   = out_y_q;
	assign out.out_z_mm   = out_z_q;
	assign out.out_color  = out_color_q;
	assign out.kept_count = cnt_out_q;
	assign out.frame_done = done_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_clear_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> pipe_empty)
		else $error("clearing pass with beats in the pipeline");

	a_epoch_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in.valid && in.ready && in.frame_start) |=>
			(epoch_q == EP_W'($past(epoch_q) + 1'b1)))
		else $error("frame start did not advance the epoch");

	a_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(out.valid && out.point_kept) |->
			((out.kept_count != '0) && (out.kept_count <= point_limit_q)))
		else $error("kept point beyond the point limit");

endmodule

// File: tb/sv/pcvd_tb_pkg.sv
package pcvd_tb_pkg;
	import pcvd_pkg::*;

	localparam int          VOXEL_MM     = 50;
	localparam int unsigned REPORT_LINES = 100;

	// One pixel beat as driven on the input channel
	typedef struct packed {
		bit signed [COORD_W-1:0] x_mm;
		bit signed [COORD_W-1:0] y_mm;
		bit signed [COORD_W-1:0] z_mm;
		bit        [COLOR_W-1:0] color_word;
		bit                      is_finite;
		bit        [PIX_W-1:0]   pixel_row;
		bit        [PIX_W-1:0]   pixel_col;
		bit                      frame_start;
		bit                      frame_end;
	} pixel_t;

	// One beat on the output channel
	typedef struct packed {
		bit                      point_kept;
		bit signed [COORD_W-1:0] x_mm;
		bit signed [COORD_W-1:0] y_mm;
		bit signed [COORD_W-1:0] z_mm;
		bit        [COLOR_W-1:0] color;
		bit        [CNT_W-1:0]   kept_count;
		bit                      frame_done;
	} point_result_t;

	class voxel_scoreboard;
		bit [CNT_W-1:0] point_limit;
		bit [LIM_W-1:0] ellipse_limit;
		bit [CNT_W-1:0] kept_in_frame;
		bit             occupied[int unsigned];
		point_result_t  expected_points[$];
		int unsigned    results_seen;
		int unsigned    errors;

		function new();
			point_limit   = POINT_LIMIT_RST;
			ellipse_limit = ELLIPSE_LIMIT_RST;
			kept_in_frame = '0;
			results_seen  = 0;
			errors        = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_POINT_LIMIT:   point_limit   = data[CNT_W-1:0];
				CFG_ELLIPSE_LIMIT: ellipse_limit = data[LIM_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_points.size();
		endfunction

		// Occupancy bit of a point; each axis index wraps at its own width
		function int unsigned voxel_cell(int x, int y, int z);
			int unsigned cx, cy, cz;
			cx = (x / VOXEL_MM) & ((1 << X_CELL_BITS_DEF) - 1);
			cy = (y / VOXEL_MM) & ((1 << Y_CELL_BITS_DEF) - 1);
			cz = (z / VOXEL_MM) & ((1 << Z_CELL_BITS_DEF) - 1);
			return (cx << (Y_CELL_BITS_DEF + Z_CELL_BITS_DEF)) | (cy << Z_CELL_BITS_DEF) | cz;
		endfunction

		// Crop, gate and dedup one accepted pixel; queue the beat it causes
		function void note_pixel(pixel_t p);
			int            x, y, z;
			longint        radius_sq;
			int unsigned   vox_id;
			bit            kept;
			point_result_t want;
			x    = $signed(p.x_mm);
			y    = $signed(p.y_mm);
			z    = $signed(p.z_mm);
			kept = 1'b0;
			if (p.frame_start) begin
				occupied.delete();
				kept_in_frame = '0;
			end
			if (p.pixel_row % SKIP_DEF == 0 && p.pixel_col % SKIP_DEF == 0 && p.is_finite &&
			    x >= BOX_X_MIN && x <= BOX_X_MAX && y >= BOX_Y_MIN && y <= BOX_Y_MAX &&
			    z >= BOX_Z_MIN && z <= BOX_Z_MAX) begin
				radius_sq = 6 * longint'(x) * x + 100 * longint'(y) * y;
				if (radius_sq <= longint'(ellipse_limit) && kept_in_frame < point_limit) begin
					vox_id = voxel_cell(x, y, z);
					if (!occupied.exists(vox_id)) begin
						occupied[vox_id] = 1'b1;
						kept_in_frame++;
						kept = 1'b1;
					end
				end
			end
			if (kept || p.frame_end) begin
				want.point_kept = kept;
				want.x_mm       = kept ? p.x_mm : '0;
				want.y_mm       = kept ? p.y_mm : '0;
				want.z_mm       = kept ? p.z_mm : '0;
				want.color      = kept ? p.color_word : '0;
				want.kept_count = kept_in_frame;
				want.frame_done = p.frame_end;
				expected_points.push_back(want);
			end
		endfunction

		task report(string what);
			errors++;
			if (errors <= REPORT_LINES)
				$display("MISMATCH result %0d: %s", results_seen, what);
		endtask

		task check_field(string name, longint got, longint want);
			if (got != want)
				report($sformatf("%s got %0d expected %0d", name, got, want));
		endtask

		task check_result(point_result_t got);
			point_result_t want;
			results_seen++;
			if (expected_points.size() == 0) begin
				report($sformatf("unexpected beat kept=%0b x=%0d y=%0d z=%0d count=%0d done=%0b",
					got.point_kept, got.x_mm, got.y_mm, got.z_mm, got.kept_count,
					got.frame_done));
				return;
			end
			want = expected_points.pop_front();
			check_field("point_kept", got.point_kept, want.point_kept);
			check_field("out_x_mm", $signed(got.x_mm), $signed(want.x_mm));
			check_field("out_y_mm", $signed(got.y_mm), $signed(want.y_mm));
			check_field("out_z_mm", $signed(got.z_mm), $signed(want.z_mm));
			check_field("out_color", got.color, want.color);
			check_field("kept_count", got.kept_count, want.kept_count);
			check_field("frame_done", got.frame_done, want.frame_done);
		endtask
	endclass

endpackage

// File: tb/sv/tb_point_crop_voxel_dedup_core.sv
module tb_point_crop_voxel_dedup_core;
	timeunit 1ns;
	timeprecision 1ps;

	import pcvd_pkg::*;
	import pcvd_tb_pkg::*;

	localparam int unsigned WATCHDOG_CYCLES = 20000;
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam int unsigned LONG_HOLD       = 150;
	localparam int unsigned HOLD_AFTER      = 60;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pcvd_in_if  in_if ();
	pcvd_out_if out_if ();

	point_crop_voxel_dedup_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in        (in_if),
		.out       (out_if)
	);

	voxel_scoreboard sb = new();

	bit            steady;
	bit            hold_done;
	int unsigned   pixels_sent;
	int unsigned   stall_cycles;
	pixel_t        last_pixel;
	point_result_t seen;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int span(input int lo, input int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	// one step either side of a bound, or on it
	function automatic int near_bound(input int lo, input int hi);
		case ($urandom_range(0, 5))
			0:       return lo - 1;
			1:       return lo;
			2:       return lo + 1;
			3:       return hi - 1;
			4:       return hi;
			default: return hi + 1;
		endcase
	endfunction

	function automatic pixel_t make_pixel(input int x, input int y, input int z,
			input bit fs = 1'b0, input bit fe = 1'b0, input int row = 0, input int col = 0,
			input bit finite = 1'b1, input int color = -1);
		pixel_t p;
		p.x_mm        = COORD_W'(x);
		p.y_mm        = COORD_W'(y);
		p.z_mm        = COORD_W'(z);
		p.color_word  = (color < 0) ? COLOR_W'($urandom) : COLOR_W'(color);
		p.is_finite   = finite;
		p.pixel_row   = PIX_W'(row);
		p.pixel_col   = PIX_W'(col);
		p.frame_start = fs;
		p.frame_end   = fe;
		return p;
	endfunction

	// Mostly in-box points on the skip grid, with repeats, edges and noise
	function automatic pixel_t random_pixel();
		pixel_t p;
		int     x, y, z;
		p.color_word = COLOR_W'($urandom);
		p.is_finite  = ($urandom_range(0, 9) != 0);
		p.pixel_row  = PIX_W'($urandom);
		p.pixel_col  = PIX_W'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			p.pixel_row[0] = 1'b0;
			p.pixel_col[0] = 1'b0;
		end
		p.frame_start = 1'b0;
		p.frame_end   = 1'b0;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				x = 700 * span(0, 3) + span(0, 60);
				y = 300 * span(-1, 1) + span(-30, 30);
				z = 600 * span(0, 2) - 100 + span(0, 60);
			end
			5: begin
				x = $signed(last_pixel.x_mm);
				y = $signed(last_pixel.y_mm);
				z = $signed(last_pixel.z_mm);
			end
			6: begin
				x = span(0, 5000);
				y = span(-3000, 3000);
				z = span(-100, 2000);
			end
			7: begin
				x = near_bound(0, 5000);
				y = near_bound(-3000, 3000);
				z = near_bound(-100, 2000);
			end
			8: begin
				x = span(-32768, 32767);
				y = span(-32768, 32767);
				z = span(-32768, 32767);
			end
			default: begin
				x = span(0, 200);
				y = span(-200, 200);
				z = span(-100, 200);
			end
		endcase
		p.x_mm     = COORD_W'(x);
		p.y_mm     = COORD_W'(y);
		p.z_mm     = COORD_W'(z);
		last_pixel = p;
		return p;
	endfunction

	// Entered and left at a falling edge; valid stays up after the beat
	task automatic send_pixel(input pixel_t p);
		if (!steady && $urandom_range(0, 4) == 0) begin
			in_if.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		in_if.valid       <= 1'b1;
		in_if.x_mm        <= p.x_mm;
		in_if.y_mm        <= p.y_mm;
		in_if.z_mm        <= p.z_mm;
		in_if.color_word  <= p.color_word;
		in_if.is_finite   <= p.is_finite;
		in_if.pixel_row   <= p.pixel_row;
		in_if.pixel_col   <= p.pixel_col;
		in_if.frame_start <= p.frame_start;
		in_if.frame_end   <= p.frame_end;
		do @(posedge clk); while (in_if.ready !== 1'b1);
		sb.note_pixel(p);
		pixels_sent++;
		@(negedge clk);
	endtask

	// Register writes only with the pipeline empty
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		in_if.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_register(idx, data);
	endtask

	task automatic send_frame(input int unsigned len, input bit with_start,
			input bit with_end, input bit noisy);
		pixel_t p;
		for (int unsigned i = 0; i < len; i++) begin
			p = random_pixel();
			if (noisy) begin
				p.frame_start = ($urandom_range(0, 3) == 0);
				p.frame_end   = ($urandom_range(0, 3) == 0);
			end else begin
				p.frame_start = with_start && (i == 0);
				p.frame_end   = with_end && (i == len - 1);
			end
			send_pixel(p);
		end
	endtask

	// Mostly whole frames; some lack a start or an end, some carry stray flags
	task automatic random_frames(input int unsigned n);
		int unsigned stop, kind, len;
		bit          keep_start;
		stop = pixels_sent + n;
		while (pixels_sent < stop) begin
			kind = $urandom_range(0, 9);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: len = span(1, 3);
				9:             len = span(16, 40);
				default:       len = span(4, 12);
			endcase
			if (kind < 8) begin
				send_frame(len, 1'b1, 1'b1, 1'b0);
			end else if (kind == 8) begin
				keep_start = $urandom_range(0, 1);
				send_frame(len, keep_start, !keep_start, 1'b0);
			end else begin
				send_frame(len, 1'b0, 1'b0, 1'b1);
			end
		end
	endtask

	task automatic run_directed();
		// no frame start yet: runs on the reset state
		send_pixel(make_pixel(100, 0, 0, 0, 0, 0, 0, 1, 0));
		send_pixel(make_pixel(120, 10, 10));                 // same voxel
		// both flags on one pixel: clear, keep, close
		send_pixel(make_pixel(0, 0, 0, 1, 1, 0, 0, 1, 24'hFFFFFF));
		send_pixel(make_pixel(0, 0, -100, 1, 0, 2, 4));
		send_pixel(make_pixel(49, 49, -100, 0, 0, 4094, 4094)); // same voxel
		// off the skip grid, non-finite, then on the grid
		send_pixel(make_pixel(200, 0, 0, 0, 0, 1, 0));
		send_pixel(make_pixel(200, 0, 0, 0, 0, 0, 4095));
		send_pixel(make_pixel(200, 0, 0, 0, 0, 0, 0, 0));
		send_pixel(make_pixel(200, 0, 0, 0, 0, 4094, 0));
		// default ellipse, just inside and just outside on each axis
		send_pixel(make_pixel(2886, 0, 0));
		send_pixel(make_pixel(2887, 0, 0));
		send_pixel(make_pixel(0, -707, 0));
		send_pixel(make_pixel(0, 708, 0));
		// frame end on a dropped pixel
		send_pixel(make_pixel(300, 0, 0, 0, 1, 3, 0));

		// box corners and the first value outside each face
		write_register(CFG_ELLIPSE_LIMIT, '1);
		send_pixel(make_pixel(5000, 3000, 2000, 1, 0));
		send_pixel(make_pixel(0, -3000, -100));
		send_pixel(make_pixel(5001, 0, 0));
		send_pixel(make_pixel(-1, 0, 0));
		send_pixel(make_pixel(0, 3001, 0));
		send_pixel(make_pixel(0, -3001, 0));
		send_pixel(make_pixel(0, 0, -101));
		send_pixel(make_pixel(0, 0, 2001));
		send_pixel(make_pixel(32767, -32768, 32767));
		send_pixel(make_pixel(-32768, 32767, -32768));
		// cell indexes wrap per axis and alias onto cell zero
		send_pixel(make_pixel(0, 0, 0));
		send_pixel(make_pixel(3200, 1600, 0));
		send_pixel(make_pixel(0, -1600, 0, 0, 1));

		// limit reached, then a limit of zero
		write_register(CFG_POINT_LIMIT, 2);
		send_pixel(make_pixel(0, 0, 0, 1, 0));
		send_pixel(make_pixel(100, 0, 0));
		send_pixel(make_pixel(200, 0, 0, 0, 1));
		write_register(CFG_POINT_LIMIT, 0);
		send_pixel(make_pixel(0, 0, 0, 1, 1));
	endtask

	// Output side: random stalls plus one long hold to back up the pipeline
	initial begin
		out_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!hold_done && pixels_sent >= HOLD_AFTER) begin
				hold_done = 1'b1;
				out_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				out_if.ready <= 1'b1;
			end else if (!steady && $urandom_range(0, 5) == 0) begin
				out_if.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				out_if.ready <= 1'b1;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	// Check every output beat
	always @(posedge clk) begin
		if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
			seen.point_kept = out_if.point_kept;
			seen.x_mm       = out_if.out_x_mm;
			seen.y_mm       = out_if.out_y_mm;
			seen.z_mm       = out_if.out_z_mm;
			seen.color      = out_if.out_color;
			seen.kept_count = out_if.kept_count;
			seen.frame_done = out_if.frame_done;
			sb.check_result(seen);
		end
	end

	// Cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
		    (out_if.valid === 1'b1 && out_if.ready === 1'b1))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_CYCLES) begin
			$display("tb_point_crop_voxel_dedup_core failed");
			$finish;
		end
	end

	initial begin
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		in_if.valid       = 1'b0;
		in_if.x_mm        = '0;
		in_if.y_mm        = '0;
		in_if.z_mm        = '0;
		in_if.color_word  = '0;
		in_if.is_finite   = 1'b0;
		in_if.pixel_row   = '0;
		in_if.pixel_col   = '0;
		in_if.frame_start = 1'b0;
		in_if.frame_end   = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();

		// everything in the box passes the ellipse; cell aliasing shows up
		write_register(CFG_POINT_LIMIT, CFG_DATA_W'(20'hFFFFF));
		write_register(CFG_ELLIPSE_LIMIT, '1);
		random_frames(150);

		// small point limit and a random ellipse
		write_register(CFG_POINT_LIMIT, span(1, 12));
		write_register(CFG_ELLIPSE_LIMIT, $urandom_range(0, 1100000000));
		random_frames(120);

		// reset values; one-pixel frames carry the frame epoch past its wrap
		write_register(CFG_POINT_LIMIT, CFG_DATA_W'(POINT_LIMIT_RST));
		write_register(CFG_ELLIPSE_LIMIT, ELLIPSE_LIMIT_RST);
		repeat (260) send_frame(1, 1'b1, 1'b1, 1'b0);

		// nothing may be kept
		write_register(CFG_POINT_LIMIT, 0);
		write_register(CFG_ELLIPSE_LIMIT, $urandom);
		random_frames(40);

		// zero ellipse: only the origin line survives
		write_register(CFG_POINT_LIMIT, $urandom_range(1, 20'hFFFFF));
		write_register(CFG_ELLIPSE_LIMIT, 0);
		random_frames(40);

		// closing stretch at full rate
		write_register(CFG_POINT_LIMIT, CFG_DATA_W'(POINT_LIMIT_RST));
		write_register(CFG_ELLIPSE_LIMIT, 32'd200000000);
		steady = 1'b1;
		random_frames(50);

		in_if.valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (sb.errors == 0)
			$display("tb_point_crop_voxel_dedup_core passed");
		else
			$display("tb_point_crop_voxel_dedup_core failed");
		$finish;
	end

endmodule
